// ===== rtl/khi_pkg.sv =====
package khi_pkg;

    localparam int NUM_BUCKETS  = 1024;
    localparam int POOL_ENTRIES = 4096;
    localparam int MAX_RESULTS  = 64;

    localparam int KEY_WORDS = 4;
    localparam int SW  = $clog2(NUM_BUCKETS);       // bucket index
    localparam int NW  = $clog2(NUM_BUCKETS + 1);   // bucket count
    localparam int EW  = $clog2(POOL_ENTRIES);      // entry index
    localparam int PW  = $clog2(POOL_ENTRIES + 1);  // pool fill / chain length
    localparam int LW  = 7;                         // limit and hit number
    localparam int CFGW = 11;

    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = 64 / DIV_BITS;
    localparam int DSW       = $clog2(DIV_STEPS);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [PW-1:0] POOL_LIM  = PW'(POOL_ENTRIES);
    localparam logic [LW-1:0] LIMIT_MAX = LW'(MAX_RESULTS);

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POOL_FULL = 2'd1;
    localparam logic [1:0] ST_TAB_FULL  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic                          mode;
        logic [KEY_WORDS-1:0][63:0]    key;
        logic [47:0]                   event_ref;
        logic [63:0]                   stamp;
        logic [63:0]                   since_bound;
        logic [63:0]                   until_bound;
        logic [LW-1:0]                 max_hits;
        logic [SW-1:0]                 home;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic          valid;
        logic [1:0]    status;
        logic          has_entry;
        logic [47:0]   hit_ref;
        logic [63:0]   hit_stamp;
        logic [LW-1:0] hit_number;
        logic          last;
    } t_result;

    function automatic logic [NW-1:0] active_n(input logic [CFGW-1:0] bc);
        logic [NW-1:0] n;
        if (bc == '0) begin
            n = NW'(1);
        end else if (32'(bc) > NUM_BUCKETS) begin
            n = NW'(NUM_BUCKETS);
        end else begin
            n = NW'(bc);
        end
        return n;
    endfunction

endpackage

// ===== rtl/khi_front.sv =====
module khi_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_hold,
    input  khi_pkg::t_item          i_item,
    input  logic [khi_pkg::NW-1:0]  i_n,
    input  logic                    i_pop,
    output logic                    o_busy,
    output khi_pkg::t_q_head        o_q
);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    t_fstate                      r_fs;
    khi_pkg::t_item               r_item;
    logic [63:0]                  r_div;
    logic [khi_pkg::NW-1:0]       r_rem;
    logic [khi_pkg::DSW-1:0]      r_step;
    logic [khi_pkg::NW-1:0]       n_rem;

    khi_pkg::t_item               r_q [khi_pkg::QDEPTH];
    logic [khi_pkg::QAW-1:0]      r_wp;
    logic [khi_pkg::QAW-1:0]      r_rp;
    logic [khi_pkg::QCW-1:0]      r_cnt;

    khi_pkg::t_item               push_item;

    logic accept;
    logic push;
    logic pop;

    assign o_busy = (r_fs != F_IDLE) || i_hold;
    assign accept = i_start && !o_busy;
    assign push   = (r_fs == F_PUSH) && (r_cnt != khi_pkg::QCW'(khi_pkg::QDEPTH));
    assign pop    = i_pop && (r_cnt != '0);

    assign o_q.valid = (r_cnt != '0);
    assign o_q.item  = r_q[r_rp];

    // The queued item carries the home bucket that the divider has just found.
    always_comb begin
        push_item      = r_item;
        push_item.home = r_rem[khi_pkg::SW-1:0];
    end

    // Restoring remainder, several dividend bits per cycle, most significant first.
    always_comb begin
        logic [khi_pkg::NW:0] t;
        t = '0;
        n_rem = r_rem;
        for (int k = 0; k < khi_pkg::DIV_BITS; k++) begin
            t = {n_rem, r_div[63-k]};
            if (t >= {1'b0, i_n}) begin
                t = t - {1'b0, i_n};
            end
            n_rem = t[khi_pkg::NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs   <= F_IDLE;
            r_step <= '0;
        end else begin
            unique case (r_fs)
                F_IDLE: begin
                    if (accept) begin
                        r_item <= i_item;
                        r_div  <= i_item.key[0];
                        r_rem  <= '0;
                        r_step <= '0;
                        r_fs   <= F_DIV;
                    end
                end
                F_DIV: begin
                    r_rem  <= n_rem;
                    r_div  <= r_div << khi_pkg::DIV_BITS;
                    r_step <= r_step + 1'b1;
                    if (r_step == khi_pkg::DSW'(khi_pkg::DIV_STEPS - 1)) begin
                        r_fs <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (push) begin
                        r_fs <= F_IDLE;
                    end
                end
                default: r_fs <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= push_item;
                r_wp <= (r_wp == khi_pkg::QAW'(khi_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == khi_pkg::QAW'(khi_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/khi_back.sv =====
module khi_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [khi_pkg::NW-1:0]  i_n,
    input  khi_pkg::t_q_head        i_q,
    output logic                    o_pop,
    output logic                    o_clearing,
    output khi_pkg::t_result        o_res
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_PRD, S_PCK, S_IWR, S_WRD, S_WCK, S_WEND
    } t_state;

    typedef struct packed {
        logic [khi_pkg::KEY_WORDS-1:0][63:0] key;
        logic [khi_pkg::EW-1:0]              head;
        logic [khi_pkg::PW-1:0]              entries;
    } t_slot;

    typedef struct packed {
        logic [47:0]            ref_v;
        logic [63:0]            stamp;
        logic [khi_pkg::EW-1:0] older;
    } t_entry;

    logic [1:0] m_state [khi_pkg::NUM_BUCKETS];
    t_slot      m_slot  [khi_pkg::NUM_BUCKETS];
    t_entry     m_entry [khi_pkg::POOL_ENTRIES];

    t_state                 r_fsm;
    khi_pkg::t_item         r_item;
    logic [khi_pkg::SW-1:0] r_clr;
    logic [khi_pkg::SW-1:0] r_idx;
    logic [khi_pkg::SW-1:0] r_slot;
    logic [khi_pkg::NW-1:0] r_pcnt;
    logic                   r_free_v;
    logic                   r_new;
    logic [khi_pkg::EW-1:0] r_head;
    logic [khi_pkg::PW-1:0] r_entries;
    logic [khi_pkg::PW-1:0] r_pool;
    logic [khi_pkg::PW-1:0] r_rem;
    logic [khi_pkg::EW-1:0] r_e;
    logic [khi_pkg::LW-1:0] r_count;
    logic [khi_pkg::LW-1:0] r_limit;
    logic                   r_pend_v;
    logic [47:0]            r_pend_ref;
    logic [63:0]            r_pend_stamp;
    khi_pkg::t_result       r_res;
    khi_pkg::t_result       n_res;

    logic [1:0]             r_rd_state;
    t_slot                  r_rd_slot;
    t_entry                 r_rd_entry;

    logic                   c_match;
    logic                   c_last_probe;
    logic [khi_pkg::SW-1:0] c_next_idx;
    logic                   c_keep;
    logic                   c_walk_end;
    logic                   c_pool_full;
    logic                   c_absent;

    assign o_pop      = (r_fsm == S_IDLE) && i_q.valid;
    assign o_clearing = (r_fsm == S_CLEAR);
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        r_rd_state <= m_state[r_idx];
        r_rd_slot  <= m_slot[r_idx];
        r_rd_entry <= m_entry[r_e];
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == S_CLEAR) begin
            m_state[r_clr] <= khi_pkg::SLOT_EMPTY;
        end else if (r_fsm == S_IWR) begin
            m_state[r_slot] <= khi_pkg::SLOT_USED;
        end
        if (r_fsm == S_IWR) begin
            m_slot[r_slot] <= '{key:     r_item.key,
                                head:    r_pool[khi_pkg::EW-1:0],
                                entries: r_new ? khi_pkg::PW'(1) : r_entries + 1'b1};
            m_entry[r_pool[khi_pkg::EW-1:0]] <= '{ref_v: r_item.event_ref,
                                                  stamp: r_item.stamp,
                                                  older: r_new ? '0 : r_head};
        end
    end

    always_comb begin
        c_match      = (r_rd_slot.key == r_item.key);
        c_last_probe = (r_pcnt + 1'b1 == i_n);
        c_next_idx   = ({1'b0, r_idx} + 1'b1 == i_n) ? '0 : r_idx + 1'b1;
        c_keep       = 1'b1;
        if ($signed(r_item.since_bound) > 0 &&
            $signed(r_rd_entry.stamp) < $signed(r_item.since_bound)) begin
            c_keep = 1'b0;
        end
        if ($signed(r_item.until_bound) > 0 &&
            $signed(r_rd_entry.stamp) > $signed(r_item.until_bound)) begin
            c_keep = 1'b0;
        end
        c_walk_end = (r_rem == '0) || (r_count == r_limit) ||
                     (khi_pkg::PW'(r_e) >= khi_pkg::POOL_LIM);
        c_pool_full = (i_q.item.mode == khi_pkg::MODE_INSERT) &&
                      (r_pool >= khi_pkg::POOL_LIM);
        c_absent    = !(r_rd_state == khi_pkg::SLOT_USED && c_match) &&
                      (r_rd_state == khi_pkg::SLOT_EMPTY || c_last_probe);
    end

    // Result for the coming cycle; a strobe lasts exactly one cycle.
    always_comb begin
        n_res = '0;
        if (r_fsm == S_IDLE && i_q.valid && c_pool_full) begin
            n_res = '{valid: 1'b1, status: khi_pkg::ST_POOL_FULL, last: 1'b1, default: '0};
        end
        if (r_fsm == S_PCK && c_absent) begin
            if (r_item.mode == khi_pkg::MODE_QUERY) begin
                n_res = '{valid: 1'b1, status: khi_pkg::ST_NOT_FOUND, last: 1'b1,
                          default: '0};
            end else if (!r_free_v && r_rd_state == khi_pkg::SLOT_USED) begin
                n_res = '{valid: 1'b1, status: khi_pkg::ST_TAB_FULL, last: 1'b1,
                          default: '0};
            end
        end
        if (r_fsm == S_IWR) begin
            n_res = '{valid: 1'b1, status: khi_pkg::ST_OK, last: 1'b1, default: '0};
        end
        // Each match is held back by one so that the final one can carry last.
        if (r_fsm == S_WCK && c_keep && r_pend_v) begin
            n_res = '{valid: 1'b1, status: khi_pkg::ST_OK, has_entry: 1'b1,
                      hit_ref: r_pend_ref, hit_stamp: r_pend_stamp,
                      hit_number: r_count, last: 1'b0};
        end
        if (r_fsm == S_WEND) begin
            if (r_pend_v) begin
                n_res = '{valid: 1'b1, status: khi_pkg::ST_OK, has_entry: 1'b1,
                          hit_ref: r_pend_ref, hit_stamp: r_pend_stamp,
                          hit_number: r_count, last: 1'b1};
            end else begin
                n_res = '{valid: 1'b1, status: khi_pkg::ST_OK, last: 1'b1, default: '0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_CLEAR;
            r_clr     <= '0;
            r_pool    <= '0;
            r_res     <= '0;
        end else begin
            r_res <= n_res;
            unique case (r_fsm)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == khi_pkg::SW'(khi_pkg::NUM_BUCKETS - 1)) begin
                        r_fsm <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q.valid) begin
                        r_item   <= i_q.item;
                        r_idx    <= i_q.item.home;
                        r_pcnt   <= '0;
                        r_free_v <= 1'b0;
                        r_limit  <= (i_q.item.max_hits == '0 ||
                                     i_q.item.max_hits > khi_pkg::LIMIT_MAX) ?
                                    khi_pkg::LIMIT_MAX : i_q.item.max_hits;
                        if (!c_pool_full) begin
                            r_fsm <= S_PRD;
                        end
                    end
                end
                S_PRD: r_fsm <= S_PCK;
                S_PCK: begin
                    if (r_rd_state == khi_pkg::SLOT_USED && c_match) begin
                        r_slot    <= r_idx;
                        r_head    <= r_rd_slot.head;
                        r_entries <= r_rd_slot.entries;
                        r_new     <= 1'b0;
                        r_rem     <= r_rd_slot.entries;
                        r_e       <= r_rd_slot.head;
                        r_count   <= '0;
                        r_pend_v  <= 1'b0;
                        r_fsm     <= (r_item.mode == khi_pkg::MODE_INSERT) ? S_IWR : S_WRD;
                    end else if (r_rd_state == khi_pkg::SLOT_EMPTY || c_last_probe) begin
                        // The key is absent; an insert claims the first free bucket seen.
                        r_new <= 1'b1;
                        if (!r_free_v && r_rd_state != khi_pkg::SLOT_USED) begin
                            r_slot <= r_idx;
                        end
                        if (r_item.mode == khi_pkg::MODE_QUERY) begin
                            r_fsm <= S_IDLE;
                        end else if (r_free_v || r_rd_state != khi_pkg::SLOT_USED) begin
                            r_fsm <= S_IWR;
                        end else begin
                            r_fsm <= S_IDLE;
                        end
                    end else begin
                        if (r_rd_state != khi_pkg::SLOT_USED && !r_free_v) begin
                            r_free_v <= 1'b1;
                            r_slot   <= r_idx;
                        end
                        r_pcnt <= r_pcnt + 1'b1;
                        r_idx  <= c_next_idx;
                        r_fsm  <= S_PRD;
                    end
                end
                S_IWR: begin
                    r_pool <= r_pool + 1'b1;
                    r_fsm  <= S_IDLE;
                end
                S_WRD: r_fsm <= c_walk_end ? S_WEND : S_WCK;
                S_WCK: begin
                    if (c_keep) begin
                        r_pend_v     <= 1'b1;
                        r_pend_ref   <= r_rd_entry.ref_v;
                        r_pend_stamp <= r_rd_entry.stamp;
                        r_count      <= r_count + 1'b1;
                    end
                    r_rem <= r_rem - 1'b1;
                    r_e   <= r_rd_entry.older;
                    r_fsm <= S_WRD;
                end
                S_WEND: begin
                    r_fsm <= S_IDLE;
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/key_hash_index_with_chains_core.sv =====
// Key index with linear-probing buckets and newest-first entry chains.
// An item is taken at a rising edge with start high and busy low. Mode 0 inserts
// (event_ref, stamp) under the 256-bit key; mode 1 queries the key's chain.
// Each result is shown for exactly one cycle with o_valid high; the receiver
// cannot stall, and o_last marks the final result of an item.
// An insert gives one result, a query one result per match or one status result.
// Flow: the home bucket (key_word0 modulo the bucket count) is worked out in the
// front part at four bits a cycle, and the item then enters a two-deep queue,
// waiting while the queue is full. The back part pops it, probes each bucket
// with a read state and a check state (registered memory reads) and writes an
// insert in its write state; a query walks each chain entry with its own read
// and check pair and closes the walk with a read state and an end state.
// The time a query takes grows with the chain length up to the limit.
// The front part accepts a new item as soon as it has queued the previous one, so
// home computation overlaps the back part's work on the previous item.
// After reset the bucket state memory is swept to empty, one bucket a cycle, with
// busy held high; the entry pool is emptied at once.
// The bucket count register may be written only while the block is idle.
module key_hash_index_with_chains_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cfg_we,
    input  logic [khi_pkg::CFGW-1:0]    i_cfg_wdata,
    input  logic                        i_mode,
    input  logic [63:0]                 i_key_word0,
    input  logic [63:0]                 i_key_word1,
    input  logic [63:0]                 i_key_word2,
    input  logic [63:0]                 i_key_word3,
    input  logic [47:0]                 i_event_ref,
    input  logic signed [63:0]          i_stamp,
    input  logic signed [63:0]          i_since_bound,
    input  logic signed [63:0]          i_until_bound,
    input  logic [6:0]                  i_max_hits,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic                        o_has_entry,
    output logic [47:0]                 o_hit_ref,
    output logic signed [63:0]          o_hit_stamp,
    output logic [6:0]                  o_hit_number,
    output logic                        o_last
);

    // Bucket count register; it resets to the full table.
    logic [khi_pkg::CFGW-1:0] r_bkt_cfg;
    logic [khi_pkg::NW-1:0]   n_active;

    khi_pkg::t_item   in_item;
    khi_pkg::t_q_head q_head;
    khi_pkg::t_result res;
    logic             pop;
    logic             clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bkt_cfg <= khi_pkg::CFGW'(khi_pkg::NUM_BUCKETS);
        end else if (i_cfg_we) begin
            r_bkt_cfg <= i_cfg_wdata;
        end
    end

    assign n_active = khi_pkg::active_n(r_bkt_cfg);

    assign in_item.mode        = i_mode;
    assign in_item.key         = {i_key_word3, i_key_word2, i_key_word1, i_key_word0};
    assign in_item.event_ref   = i_event_ref;
    assign in_item.stamp       = i_stamp;
    assign in_item.since_bound = i_since_bound;
    assign in_item.until_bound = i_until_bound;
    assign in_item.max_hits    = i_max_hits;
    assign in_item.home        = '0;

    // The front part takes items and finds their home buckets.
    khi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_hold  (clearing),
        .i_item  (in_item),
        .i_n     (n_active),
        .i_pop   (pop),
        .o_busy  (busy),
        .o_q     (q_head)
    );

    // The back part probes the buckets, updates the pool and walks chains.
    khi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_n        (n_active),
        .i_q        (q_head),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_res      (res)
    );

    assign o_valid      = res.valid;
    assign o_status     = res.status;
    assign o_has_entry  = res.has_entry;
    assign o_hit_ref    = res.hit_ref;
    assign o_hit_stamp  = res.hit_stamp;
    assign o_hit_number = res.hit_number;
    assign o_last       = res.last;

    // No item is taken while the bucket state is still being swept.
    a_busy_in_clear: assert property (@(posedge i_clk) clearing |-> busy)
        else $error("item could be accepted during the clearing sweep");

    // A result that carries an entry always has status ok and a nonzero number.
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_entry) |-> (o_status == khi_pkg::ST_OK && o_hit_number != '0))
        else $error("entry result with bad status or number");

    // A result without an entry is always the only and final one of its item.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_entry) |-> o_last)
        else $error("status result not marked last");

    // Consecutive matches of one query count up by one.
    a_hit_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_entry && !o_last) ##1 (o_valid && o_has_entry)
        |-> (o_hit_number == $past(o_hit_number) + 7'd1))
        else $error("hit numbers out of sequence");

endmodule

// ===== dv/key_hash_index_with_chains_core_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the key index core.
// An initial block builds the stimulus phase by phase into a queue of pending
// items. A driver at the falling edge feeds that queue to the block in bursts
// with random gaps between them. A monitor at the rising edge predicts the
// results of each accepted item and checks every strobed result against the
// oldest expectation. The bucket count is only changed between phases, once
// the block has drained.
module key_hash_index_with_chains_core_tb;

    typedef struct {
        logic        mode;
        logic [63:0] kw [4];
        logic [47:0] eref;
        logic [63:0] stamp;
        logic [63:0] since_b;
        logic [63:0] until_b;
        logic [6:0]  maxh;
    } t_req;

    typedef struct {
        logic [1:0]  status;
        logic        has;
        logic [47:0] href;
        logic [63:0] hstamp;
        logic [6:0]  hnum;
        logic        last;
    } t_hit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [khi_pkg::CFGW-1:0] i_cfg_wdata = '0;
    logic i_mode = 1'b0;
    logic [63:0] i_key_word0 = '0, i_key_word1 = '0, i_key_word2 = '0, i_key_word3 = '0;
    logic [47:0] i_event_ref = '0;
    logic signed [63:0] i_stamp = '0, i_since_bound = '0, i_until_bound = '0;
    logic [6:0] i_max_hits = '0;
    logic o_valid, o_has_entry, o_last;
    logic [1:0] o_status;
    logic [47:0] o_hit_ref;
    logic signed [63:0] o_hit_stamp;
    logic [6:0] o_hit_number;

    key_hash_index_with_chains_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_mode(i_mode), .i_key_word0(i_key_word0), .i_key_word1(i_key_word1),
        .i_key_word2(i_key_word2), .i_key_word3(i_key_word3),
        .i_event_ref(i_event_ref), .i_stamp(i_stamp),
        .i_since_bound(i_since_bound), .i_until_bound(i_until_bound),
        .i_max_hits(i_max_hits), .o_valid(o_valid), .o_status(o_status),
        .o_has_entry(o_has_entry), .o_hit_ref(o_hit_ref), .o_hit_stamp(o_hit_stamp),
        .o_hit_number(o_hit_number), .o_last(o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Shadow copy of the index: buckets, entry pool and the bucket count.
    logic [1:0]  bkt_state [khi_pkg::NUM_BUCKETS];
    logic [63:0] bkt_key   [khi_pkg::NUM_BUCKETS][4];
    int          bkt_head  [khi_pkg::NUM_BUCKETS];
    int          bkt_len   [khi_pkg::NUM_BUCKETS];
    logic [47:0] ent_ref   [khi_pkg::POOL_ENTRIES];
    logic [63:0] ent_stamp [khi_pkg::POOL_ENTRIES];
    int          ent_older [khi_pkg::POOL_ENTRIES];
    int          pool_fill;
    logic [khi_pkg::CFGW-1:0] bucket_cnt;

    t_req pending_items [$];
    t_hit awaited_hits [$];
    t_req held_item;
    logic taken = 1'b0;
    int gap_left = 0;
    int burst_left = 1;
    int mismatches = 0;
    int items_in = 0;
    int hits_out = 0;
    int entry_hits = 0;
    int status_seen [4];
    int idle_cycles = 0;

    function automatic int live_buckets();
        if (bucket_cnt == '0) begin
            return 1;
        end else if (int'(bucket_cnt) > khi_pkg::NUM_BUCKETS) begin
            return khi_pkg::NUM_BUCKETS;
        end
        return int'(bucket_cnt);
    endfunction

    function automatic bit same_key(int b, t_req r);
        for (int w = 0; w < 4; w++) begin
            if (bkt_key[b][w] != r.kw[w]) return 0;
        end
        return 1;
    endfunction

    // Probe from the home bucket; -1 when the key is not held.
    function automatic int locate_bucket(t_req r);
        int n;
        int idx;
        n = live_buckets();
        idx = int'(r.kw[0] % 64'(n));
        for (int i = 0; i < n; i++) begin
            if (bkt_state[idx] == khi_pkg::SLOT_EMPTY) return -1;
            if (bkt_state[idx] == khi_pkg::SLOT_USED && same_key(idx, r)) return idx;
            idx = (idx + 1 == n) ? 0 : idx + 1;
        end
        return -1;
    endfunction

    function automatic void push_hit(logic [1:0] st, logic has, logic [47:0] rf,
                                     logic [63:0] sp, logic [6:0] num, logic lst);
        t_hit h;
        h.status = st; h.has = has; h.href = rf; h.hstamp = sp; h.hnum = num;
        h.last = lst;
        awaited_hits.push_back(h);
    endfunction

    // Applies one accepted item to the shadow index and queues its results.
    function automatic void apply_item(t_req r);
        int b;
        int n;
        int idx;
        int e;
        int left;
        int limit;
        int count;
        bit found;
        logic signed [63:0] st, lo, hi;
        b = locate_bucket(r);
        if (r.mode == khi_pkg::MODE_INSERT) begin
            if (pool_fill >= khi_pkg::POOL_ENTRIES) begin
                push_hit(khi_pkg::ST_POOL_FULL, 0, '0, '0, '0, 1);
                return;
            end
            if (b < 0) begin
                n = live_buckets();
                idx = int'(r.kw[0] % 64'(n));
                found = 0;
                for (int i = 0; i < n; i++) begin
                    if (bkt_state[idx] != khi_pkg::SLOT_USED) begin
                        found = 1;
                        break;
                    end
                    idx = (idx + 1 == n) ? 0 : idx + 1;
                end
                if (!found) begin
                    push_hit(khi_pkg::ST_TAB_FULL, 0, '0, '0, '0, 1);
                    return;
                end
                for (int w = 0; w < 4; w++) bkt_key[idx][w] = r.kw[w];
                bkt_head[idx] = 0;
                bkt_len[idx] = 0;
                bkt_state[idx] = khi_pkg::SLOT_USED;
                b = idx;
            end
            ent_ref[pool_fill] = r.eref;
            ent_stamp[pool_fill] = r.stamp;
            ent_older[pool_fill] = bkt_head[b];
            bkt_head[b] = pool_fill;
            bkt_len[b]++;
            pool_fill++;
            push_hit(khi_pkg::ST_OK, 0, '0, '0, '0, 1);
            return;
        end
        if (b < 0) begin
            push_hit(khi_pkg::ST_NOT_FOUND, 0, '0, '0, '0, 1);
            return;
        end
        lo = r.since_b;
        hi = r.until_b;
        limit = int'(r.maxh);
        if (limit == 0 || limit > khi_pkg::MAX_RESULTS) limit = khi_pkg::MAX_RESULTS;
        left = bkt_len[b];
        e = bkt_head[b];
        count = 0;
        while (left > 0 && count < limit && e < khi_pkg::POOL_ENTRIES) begin
            st = ent_stamp[e];
            if (!((lo > 0 && st < lo) || (hi > 0 && st > hi))) begin
                count++;
                push_hit(khi_pkg::ST_OK, 1, ent_ref[e], ent_stamp[e], 7'(count), 0);
            end
            left--;
            e = ent_older[e];
        end
        if (count == 0) begin
            push_hit(khi_pkg::ST_OK, 0, '0, '0, '0, 1);
        end else begin
            awaited_hits[awaited_hits.size() - 1].last = 1;
        end
    endfunction

    // Monitor, predictor and watchdog, all sampled at the rising edge.
    always @(posedge i_clk) begin
        t_hit h;
        taken <= i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            hits_out++;
            status_seen[o_status]++;
            if (o_has_entry) entry_hits++;
            if (awaited_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result, status %0d", o_status);
            end else begin
                h = awaited_hits.pop_front();
                if (o_status !== h.status || o_has_entry !== h.has
                    || o_hit_ref !== h.href || o_hit_stamp !== h.hstamp
                    || o_hit_number !== h.hnum || o_last !== h.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp st=%0d has=%0d ref=%h stamp=%h num=%0d last=%0d",
                                 h.status, h.has, h.href, h.hstamp, h.hnum, h.last);
                        $display("         got st=%0d has=%0d ref=%h stamp=%h num=%0d last=%0d",
                                 o_status, o_has_entry, o_hit_ref, o_hit_stamp,
                                 o_hit_number, o_last);
                    end
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            apply_item(held_item);
            items_in++;
        end
        // The longest honest silence is the post-reset sweep or a long probe
        // followed by a full chain walk; this limit is many times either.
        if (i_rst_n && ((start && !busy) || o_valid)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= 40000) begin
                $display("key_hash_index_with_chains_core_tb: FAIL");
                $finish;
            end
        end
    end

    // Driver: holds an item until it is taken, then moves on in bursts.
    always @(negedge i_clk) begin
        t_req r;
        if (i_rst_n && (!start || taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_items.size() > 0) begin
                r = pending_items.pop_front();
                held_item = r;
                i_mode <= r.mode;
                i_key_word0 <= r.kw[0]; i_key_word1 <= r.kw[1];
                i_key_word2 <= r.kw[2]; i_key_word3 <= r.kw[3];
                i_event_ref <= r.eref; i_stamp <= r.stamp;
                i_since_bound <= r.since_b; i_until_bound <= r.until_b;
                i_max_hits <= r.maxh;
                start <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // A small set of keys is reused so that chains grow and homes collide.
    t_req key_set [16];

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rnd_stamp();
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(1, 100));
            1: return -64'($urandom_range(1, 100));
            default: return rnd64();
        endcase
    endfunction

    function automatic logic [63:0] rnd_bound();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return -64'($urandom_range(0, 50));
            2: return 64'($urandom_range(1, 100));
            3: return rnd64();
            default: return 64'($urandom_range(30, 70));
        endcase
    endfunction

    function automatic t_req make_item(logic mode, int key_sel, logic [63:0] sp,
                                       logic [63:0] lo, logic [63:0] hi, logic [6:0] mh);
        t_req r;
        r = key_set[key_sel];
        r.mode = mode;
        r.eref = {$urandom(), 16'($urandom())};
        r.stamp = sp;
        r.since_b = lo;
        r.until_b = hi;
        r.maxh = mh;
        return r;
    endfunction

    task automatic add_random(int count);
        t_req r;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                // Noise: a fresh random key, mostly absent.
                r = make_item(1'($urandom()), 0, rnd_stamp(), rnd_bound(), rnd_bound(),
                              7'($urandom()));
                for (int w = 0; w < 4; w++) r.kw[w] = rnd64();
            end else begin
                r = make_item($urandom_range(0, 2) == 0, $urandom_range(0, 15), rnd_stamp(),
                              rnd_bound(), rnd_bound(),
                              ($urandom_range(0, 3) == 0) ? 7'($urandom()) :
                                                            7'($urandom_range(0, 8)));
            end
            pending_items.push_back(r);
        end
    endtask

    // Waits until every item is in and every result is out, then lets the
    // back part settle before anything else touches the block.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() > 0 || start || awaited_hits.size() > 0 || busy);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_buckets(logic [khi_pkg::CFGW-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        bucket_cnt = v;
    endtask

    initial begin
        t_req r;
        for (int b = 0; b < khi_pkg::NUM_BUCKETS; b++) bkt_state[b] = khi_pkg::SLOT_EMPTY;
        pool_fill = 0;
        bucket_cnt = khi_pkg::CFGW'(khi_pkg::NUM_BUCKETS);
        for (int s = 0; s < 4; s++) status_seen[s] = 0;
        for (int k = 0; k < 16; k++) begin
            for (int w = 0; w < 4; w++) key_set[k].kw[w] = rnd64();
            // Half the keys share tiny hashes so probing wraps and collides.
            if (k < 8) key_set[k].kw[0] = 64'($urandom_range(0, 9));
        end
        for (int w = 0; w < 4; w++) begin
            key_set[14].kw[w] = '1;
            key_set[15].kw[w] = '0;
        end
        // Same hash and low words as key 0, differing only in the top word.
        key_set[13] = key_set[0];
        key_set[13].kw[3] = ~key_set[0].kw[3];

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset bucket count.
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 0, '0, '0, '0, 7'd0));
        r = make_item(khi_pkg::MODE_INSERT, 0, 64'h7fff_ffff_ffff_ffff, '0, '0, 7'd0);
        r.eref = '1;
        pending_items.push_back(r);
        r = make_item(khi_pkg::MODE_INSERT, 0, 64'h8000_0000_0000_0000, '0, '0, 7'd0);
        r.eref = '0;
        pending_items.push_back(r);
        pending_items.push_back(make_item(khi_pkg::MODE_INSERT, 0, 64'd50, '0, '0, 7'd0));
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 0, '0, '0, '0, 7'd0));
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 0, '0, 64'd40, 64'd60, 7'd5));
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 0, '0, 64'd1000, 64'd999,
                                          7'd5));
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 0, '0, -64'd5, -64'd5, 7'd1));
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 0, '0, '0, '0, 7'd127));
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 0, '0,
                                          64'h7fff_ffff_ffff_ffff, '0, 7'd64));
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 13, '0, '0, '0, 7'd0));
        pending_items.push_back(make_item(khi_pkg::MODE_INSERT, 13, 64'd7, '0, '0, 7'd0));
        pending_items.push_back(make_item(khi_pkg::MODE_INSERT, 14, rnd64(), '0, '0, 7'd0));
        pending_items.push_back(make_item(khi_pkg::MODE_INSERT, 15, rnd64(), '0, '0, 7'd0));
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 14, '0, '0, '0, 7'd0));
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 15, '0, '0,
                                          64'h7fff_ffff_ffff_ffff, 7'd127));
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 13, '0, '0, '0, 7'd0));
        add_random(45);
        drain();

        // One bucket: only its key is reachable; other inserts hit a full table.
        set_buckets(khi_pkg::CFGW'(1));
        pending_items.push_back(make_item(khi_pkg::MODE_INSERT, 3, 64'd9, '0, '0, 7'd0));
        pending_items.push_back(make_item(khi_pkg::MODE_QUERY, 15, '0, '0, '0, 7'd0));
        add_random(30);
        drain();
        set_buckets('0);
        add_random(30);
        drain();
        set_buckets('1);
        add_random(50);
        drain();
        set_buckets(khi_pkg::CFGW'(7));
        add_random(60);
        drain();
        set_buckets(khi_pkg::CFGW'($urandom_range(2, 1024)));
        add_random(60);
        drain();

        // Back at the full table, a last random run reads the chains back.
        set_buckets(khi_pkg::CFGW'(khi_pkg::NUM_BUCKETS));
        add_random(20);
        drain();

        $display("items accepted %0d, results %0d with %0d entries", items_in, hits_out,
                 entry_hits);
        $display("status ok %0d, pool full %0d, table full %0d, not found %0d",
                 status_seen[khi_pkg::ST_OK], status_seen[khi_pkg::ST_POOL_FULL],
                 status_seen[khi_pkg::ST_TAB_FULL], status_seen[khi_pkg::ST_NOT_FOUND]);
        if (mismatches == 0 && awaited_hits.size() == 0) begin
            $display("key_hash_index_with_chains_core_tb: PASS");
        end else begin
            $display("key_hash_index_with_chains_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/khi_pkg.sv
rtl/khi_front.sv
rtl/khi_back.sv
rtl/key_hash_index_with_chains_core.sv
dv/key_hash_index_with_chains_core_tb.sv
